// ===== src/base64_stream_decoder_unit_defines.svh =====
// Assertion macros used by the Base64 stream decoder's result register (b64_emit).
// Depends on clk and arst_n being visible in the module that expands them.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define B64_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define B64_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/b64_pkg.sv =====
// Shared types, constants and the character classifier of the Base64 decoder.
// No dependencies; every other file but the assertion macro header imports this package.
package b64_pkg;

	localparam int CHAR_W         = 8;
	localparam int TOTAL_W        = 24;
	localparam int QUAD_W         = 24;
	localparam int JOB_BYTES      = 6;
	localparam int JOB_W          = JOB_BYTES * CHAR_W;
	localparam int COUNT_BITS_DEF = 24;

	localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D; // '='
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B; // '+'
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F; // '/'

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	typedef struct packed {
		logic       is_valid;
		logic       is_pad;
		logic [5:0] val;
	} sextet_t;

	// One burst of results caused by a single input character.
	typedef struct packed {
		logic [JOB_W-1:0]   bytes;      // first byte in the top lane
		logic [2:0]         nbytes;     // 0 to JOB_BYTES
		logic               has_status;
		logic               status;
		logic [TOTAL_W-1:0] total;
	} job_t;

	function automatic sextet_t b64_classify(input logic [CHAR_W-1:0] c);
		sextet_t s;
		s.is_valid = 1'b1;
		s.is_pad   = 1'b0;
		s.val      = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == CHAR_PLUS) begin
			s.val = 6'd62;
		end else if (c == CHAR_SLASH) begin
			s.val = 6'd63;
		end else if (c == CHAR_PAD) begin
			s.is_pad = 1'b1;
		end else begin
			s.is_valid = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== src/b64_char_if.sv =====
// Request channels of the Base64 decoder: encoded characters in, results out.
// Depends on b64_pkg for field widths.
interface b64_char_if import b64_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              final_char;

	modport source (output valid, char_in, final_char, input ready);
	modport sink   (input valid, char_in, final_char, output ready);
endinterface

interface b64_result_if import b64_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [CHAR_W-1:0]  data_byte;
	logic               status;
	logic [TOTAL_W-1:0] byte_total;
	logic               last_of_run;

	modport source (output valid, kind, data_byte, status, byte_total, last_of_run,
		input ready);
	modport sink   (input valid, kind, data_byte, status, byte_total, last_of_run,
		output ready);
endinterface

// ===== src/base64_stream_decoder_unit.sv =====
// Top level of the Base64 (standard alphabet) stream decoder.
// Depends on b64_pkg, b64_char_if / b64_result_if, b64_core and b64_emit.
//
// One encoded character enters per request on in_ch; decoded bytes and a closing
// status leave on out_ch, one result per request. Characters outside A-Z a-z 0-9
// + / are skipped, '=' decodes as a zero sextet, and each complete quad is held
// back until the next quad completes or the stream ends, so that the final quad
// can be trimmed to one or two bytes by its padding. The character marked
// final_char closes the stream with a status result: status 0 and the byte
// count (saturating at 2^24-1, internally at 2^COUNT_BITS-1), or status 1 when
// no valid character was seen or a partial quad remains, in which case the held
// quad is dropped. Timing: a character passes through an input register, then
// the quad logic builds its whole burst of results combinationally and loads
// it into the result register. Characters that cause at most one result stream
// at one per cycle while out_ch is ready. A character that causes n results (a
// finished quad gives three, the end of a stream up to seven) holds the result
// register until all n have gone, since out_ch moves one result per request;
// during that time characters that cause no result keep passing through, and
// the input register holds the first character that does until the last result
// of the burst goes. last_of_run marks the final result of each burst. Reset
// clears all stream state; there is no setup.
module base64_stream_decoder_unit import b64_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	b64_char_if.sink     in_ch,
	b64_result_if.source out_ch
);

	job_t job;
	logic job_vld;
	logic job_rdy;

	// Classify, assemble quads and build the result burst for each character.
	b64_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.job    (job),
		.job_vld(job_vld),
		.job_rdy(job_rdy)
	);

	// Hold the burst and advance one result per output request.
	b64_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.job_vld(job_vld),
		.job_rdy(job_rdy),
		.out_ch (out_ch)
	);

endmodule

// ===== src/b64_core.sv =====
// Input register, quad assembly state and result-burst builder of the decoder.
// Depends on b64_pkg and the b64_char_if interface.
module b64_core import b64_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	b64_char_if.sink in_ch,
	output job_t   job,
	output logic   job_vld,
	input  logic   job_rdy
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic              vld_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              final_s1;

	logic [1:0]            phase_q;
	logic [17:0]           buf_q;
	logic [1:0]            pm_q;
	logic                  any_q;
	logic                  held_v_q;
	logic [QUAD_W-1:0]     held_b_q;
	logic [1:0]            held_pm_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic [1:0]            phase_n;
	logic [17:0]           buf_n;
	logic [1:0]            pm_n;
	logic                  any_n;
	logic                  held_v_n;
	logic [QUAD_W-1:0]     held_b_n;
	logic [1:0]            held_pm_n;
	logic [COUNT_BITS-1:0] cnt_n;

	sextet_t               sx_c;
	logic [5:0]            sx_val;
	logic [1:0]            pm_new;
	logic                  complete;
	logic                  ok;
	logic [1:0]            keep;
	logic [2:0]            n1;
	logic [2:0]            nbytes;
	logic [COUNT_BITS:0]   cnt_sum;
	logic [TOTAL_W-1:0]    total_c;
	logic                  consume;

	// Drain the input register when the character causes no burst or the emitter takes it.
	assign job_vld     = vld_s1 && (nbytes != 3'd0 || final_s1);
	assign consume     = vld_s1 && (!job_vld || job_rdy);
	assign in_ch.ready = !vld_s1 || consume;

	always_comb begin
		sx_c     = b64_classify(char_s1);
		sx_val   = sx_c.is_pad ? 6'd0 : sx_c.val;
		complete = sx_c.is_valid && phase_q == 2'd3;
		pm_new   = (phase_q == 2'd0) ? 2'b00 : pm_q;
		pm_new   = pm_new | {sx_c.is_pad && phase_q == 2'd3, sx_c.is_pad && phase_q == 2'd2};

		phase_n   = phase_q;
		buf_n     = buf_q;
		pm_n      = pm_q;
		held_v_n  = held_v_q;
		held_b_n  = held_b_q;
		held_pm_n = held_pm_q;
		any_n     = any_q | sx_c.is_valid;

		if (complete) begin
			held_v_n  = 1'b1;
			held_b_n  = {buf_q, sx_val};
			held_pm_n = pm_new;
			buf_n     = '0;
			phase_n   = 2'd0;
			pm_n      = 2'b00;
		end else if (sx_c.is_valid) begin
			buf_n   = {buf_q[11:0], sx_val};
			phase_n = 2'(phase_q + 2'd1);
			pm_n    = pm_new;
		end

		// Flush the held quad trimmed by its padding.
		ok   = final_s1 && any_n && phase_n == 2'd0 && held_v_n;
		keep = held_pm_n[0] ? 2'd1 : (held_pm_n[1] ? 2'd2 : 2'd3);
		n1   = (complete && held_v_q) ? 3'd3 : 3'd0;
		nbytes = 3'(n1 + {1'b0, (ok ? keep : 2'd0)});

		cnt_sum = {1'b0, cnt_q} + (COUNT_BITS+1)'(nbytes);
		cnt_n   = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[COUNT_BITS-1:0];

		job.bytes      = (n1 != 3'd0) ? {held_b_q, held_b_n} : {held_b_n, {QUAD_W{1'b0}}};
		job.nbytes     = nbytes;
		job.has_status = final_s1;
		job.status     = ok ? STATUS_OK : STATUS_BAD;
		job.total      = total_c;
	end

	generate
		if (COUNT_BITS > TOTAL_W) begin : g_sat
			assign total_c = (|cnt_n[COUNT_BITS-1:TOTAL_W]) ? {TOTAL_W{1'b1}}
				: cnt_n[TOTAL_W-1:0];
		end else begin : g_ext
			assign total_c = TOTAL_W'(cnt_n);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1  <= in_ch.char_in;
			final_s1 <= in_ch.final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			buf_q     <= '0;
			pm_q      <= '0;
			any_q     <= 1'b0;
			held_v_q  <= 1'b0;
			held_b_q  <= '0;
			held_pm_q <= '0;
			cnt_q     <= '0;
		end else if (consume) begin
			if (final_s1) begin
				phase_q   <= '0;
				buf_q     <= '0;
				pm_q      <= '0;
				any_q     <= 1'b0;
				held_v_q  <= 1'b0;
				held_b_q  <= '0;
				held_pm_q <= '0;
				cnt_q     <= '0;
			end else begin
				phase_q   <= phase_n;
				buf_q     <= buf_n;
				pm_q      <= pm_n;
				any_q     <= any_n;
				held_v_q  <= held_v_n;
				held_b_q  <= held_b_n;
				held_pm_q <= held_pm_n;
				cnt_q     <= cnt_n;
			end
		end
	end

endmodule

// ===== src/b64_emit.sv =====
// Result register of the decoder: plays one burst out, one result per request.
// Depends on b64_pkg, the b64_result_if interface and the assertion macros.
`include "base64_stream_decoder_unit_defines.svh"

module b64_emit import b64_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  job_t  job,
	input  logic  job_vld,
	output logic  job_rdy,
	b64_result_if.source out_ch
);

	logic               busy_s2;
	logic [JOB_W-1:0]   bytes_s2;
	logic [2:0]         left_s2;
	logic               stat_pend_s2;
	logic               status_s2;
	logic [TOTAL_W-1:0] total_s2;

	logic out_hs;
	logic last_res;
	logic load;

	assign last_res = (left_s2 == 3'd1 && !stat_pend_s2) || left_s2 == 3'd0;
	assign out_hs   = out_ch.valid && out_ch.ready;
	assign job_rdy  = !busy_s2 || (out_hs && last_res);
	assign load     = job_vld && job_rdy;

	assign out_ch.valid       = busy_s2;
	assign out_ch.kind        = (left_s2 == 3'd0) ? KIND_STATUS : KIND_DATA;
	assign out_ch.data_byte   = (left_s2 != 3'd0) ? bytes_s2[JOB_W-1 -: CHAR_W] : '0;
	assign out_ch.status      = (left_s2 == 3'd0) ? status_s2 : STATUS_OK;
	assign out_ch.byte_total  = (left_s2 == 3'd0) ? total_s2 : '0;
	assign out_ch.last_of_run = last_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2      <= 1'b0;
			left_s2      <= '0;
			stat_pend_s2 <= 1'b0;
		end else if (load) begin
			busy_s2      <= 1'b1;
			left_s2      <= job.nbytes;
			stat_pend_s2 <= job.has_status;
		end else if (out_hs) begin
			if (last_res) begin
				busy_s2 <= 1'b0;
			end
			if (left_s2 != 3'd0) begin
				left_s2 <= 3'(left_s2 - 3'd1);
			end else begin
				stat_pend_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2  <= job.bytes;
			status_s2 <= job.status;
			total_s2  <= job.total;
		end else if (out_hs) begin
			bytes_s2 <= {bytes_s2[JOB_W-CHAR_W-1:0], {CHAR_W{1'b0}}};
		end
	end

	`B64_ASSERT_IMP(a_status_pending, busy_s2 && left_s2 == 3'd0, stat_pend_s2, "status lost")
	`B64_ASSERT_IMP(a_left_bound, busy_s2, left_s2 <= 3'(JOB_BYTES), "byte count beyond burst size")
	`B64_ASSERT_NXT(a_drain_idle, out_hs && last_res && !load, !busy_s2, "busy after last result")
	`B64_ASSERT_IMP(a_empty_burst, load, job.nbytes != 3'd0 || job.has_status, "empty burst loaded")

endmodule

// ===== test/tb_base64_stream_decoder_unit.sv =====
// Self-checking bench for base64_stream_decoder_unit: directed and random character streams.
// Depends on b64_pkg, b64_char_if / b64_result_if and the decoder RTL; predicts in a scoreboard.
module tb_base64_stream_decoder_unit;
	import b64_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// What one character means to the decoder.
	typedef enum logic [1:0] {CH_SKIP, CH_DATA, CH_PAD} char_class_t;

	// One result as it leaves out_ch.
	typedef struct packed {
		logic               kind;
		logic [CHAR_W-1:0]  data_byte;
		logic               status;
		logic [TOTAL_W-1:0] byte_total;
		logic               last_of_run;
	} b64_result_t;

	// Decoder state copy plus the queue of decoded results not yet seen on out_ch.
	class b64_decode_scoreboard;
		logic [1:0]                quad_phase;
		logic [17:0]               sextet_acc;
		logic [1:0]                pad_flags;
		bit                        stream_has_valid;
		bit                        held_ok;
		logic [QUAD_W-1:0]         held_quad;
		logic [1:0]                held_pads;
		logic [COUNT_BITS_DEF-1:0] byte_count;
		b64_result_t               awaited_results[$];
		b64_result_t               burst_q[$];
		int                        accepted;
		int                        fails;

		function new();
			accepted = 0;
			fails    = 0;
			clear_stream();
		endfunction

		static function char_class_t classify(input logic [CHAR_W-1:0] c,
			output logic [5:0] sx);
			sx = '0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				sx = 6'(c - 8'h41);
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				sx = 6'(c - 8'h61 + 26);
			end else if (c >= 8'h30 && c <= 8'h39) begin
				sx = 6'(c - 8'h30 + 52);
			end else if (c == CHAR_PLUS) begin
				sx = 6'd62;
			end else if (c == CHAR_SLASH) begin
				sx = 6'd63;
			end else if (c == CHAR_PAD) begin
				return CH_PAD;
			end else begin
				return CH_SKIP;
			end
			return CH_DATA;
		endfunction

		function void clear_stream();
			quad_phase       = '0;
			sextet_acc       = '0;
			pad_flags        = '0;
			stream_has_valid = 0;
			held_ok          = 0;
			held_quad        = '0;
			held_pads        = '0;
			byte_count       = '0;
		endfunction

		function void add_byte(logic [CHAR_W-1:0] b);
			b64_result_t r;
			r           = '0;
			r.kind      = KIND_DATA;
			r.data_byte = b;
			if (byte_count != '1)
				byte_count++;
			burst_q.push_back(r);
		endfunction

		// Work out every result that one accepted character causes.
		function void note_char(logic [CHAR_W-1:0] c, logic fin);
			char_class_t cls;
			logic [5:0]  sx;
			b64_result_t r;
			int          keep;
			accepted++;
			burst_q.delete();
			cls = classify(c, sx);
			if (cls != CH_SKIP) begin
				stream_has_valid = 1;
				if (quad_phase == 2'd0)
					pad_flags = '0;
				if (cls == CH_PAD && quad_phase == 2'd2)
					pad_flags[0] = 1'b1;
				if (cls == CH_PAD && quad_phase == 2'd3)
					pad_flags[1] = 1'b1;
				if (quad_phase != 2'd3) begin
					sextet_acc = {sextet_acc[11:0], sx};
					quad_phase++;
				end else begin
					if (held_ok) begin
						for (int i = 2; i >= 0; i--)
							add_byte(held_quad[8*i +: 8]);
					end
					held_ok    = 1;
					held_quad  = {sextet_acc, sx};
					held_pads  = pad_flags;
					sextet_acc = '0;
					quad_phase = '0;
					pad_flags  = '0;
				end
			end
			if (fin) begin
				r        = '0;
				r.kind   = KIND_STATUS;
				r.status = STATUS_BAD;
				if (stream_has_valid && quad_phase == 2'd0 && held_ok) begin
					keep = held_pads[0] ? 1 : (held_pads[1] ? 2 : 3);
					for (int i = 0; i < keep; i++)
						add_byte(held_quad[23-8*i -: 8]);
					r.status = STATUS_OK;
				end
				if (byte_count > {TOTAL_W{1'b1}})
					r.byte_total = '1;
				else
					r.byte_total = TOTAL_W'(byte_count);
				burst_q.push_back(r);
				clear_stream();
			end
			if (burst_q.size() > 0)
				burst_q[burst_q.size()-1].last_of_run = 1'b1;
			foreach (burst_q[i])
				awaited_results.push_back(burst_q[i]);
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				fails++;
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$time, name, want, got);
			end
		endfunction

		function void check_result(b64_result_t got);
			b64_result_t want;
			if (awaited_results.size() == 0) begin
				fails++;
				$display("%0t: unexpected result, expected none, got kind %0d byte 0x%0h",
					$time, got.kind, got.data_byte);
				return;
			end
			want = awaited_results.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("data_byte", want.data_byte, got.data_byte);
			check_field("status", want.status, got.status);
			check_field("byte_total", want.byte_total, got.byte_total);
			check_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b64_char_if   in_ch ();
	b64_result_if out_ch ();

	base64_stream_decoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	b64_decode_scoreboard sb = new();

	bit quiet  = 0; // set for the tail of the run: no idling on either side

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Map a sextet index to its character; 64 gives the pad character.
	function automatic logic [CHAR_W-1:0] alphabet_char(int idx);
		if (idx < 26)
			return 8'(8'h41 + idx);
		if (idx < 52)
			return 8'(8'h61 + idx - 26);
		if (idx < 62)
			return 8'(8'h30 + idx - 52);
		if (idx == 62)
			return CHAR_PLUS;
		if (idx == 63)
			return CHAR_SLASH;
		return CHAR_PAD;
	endfunction

	// Draw a random byte that the decoder skips.
	function automatic logic [CHAR_W-1:0] skip_char();
		logic [CHAR_W-1:0] c;
		logic [5:0]        sx;
		do
			c = 8'($urandom_range(0, 255));
		while (b64_decode_scoreboard::classify(c, sx) != CH_SKIP);
		return c;
	endfunction

	// Offer one character and hold it until the block takes the request.
	// Now and then drop valid for a burst first, so gaps land on every phase.
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.char_in    <= c;
		in_ch.final_char <= fin;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_char(c, fin);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	// Build one stream. Most are well formed (whole quads, optional padding on the
	// last one, stray skipped bytes in between); some lose or gain a few
	// characters; a few are pure noise.
	task automatic send_random_stream();
		logic [CHAR_W-1:0] text[$];
		int                mode;
		int                quads;
		int                pads;
		int                n;
		mode = $urandom_range(0, 9);
		if (mode == 9) begin
			n = $urandom_range(1, 8);
			repeat (n) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			quads = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
			pads  = $urandom_range(0, 2);
			for (int q = 0; q < quads; q++) begin
				for (int k = 0; k < 4; k++) begin
					if (q == quads - 1 && pads != 0 && k >= 4 - pads)
						text.push_back(CHAR_PAD);
					else
						text.push_back(alphabet_char($urandom_range(0, 63)));
				end
			end
			if (mode >= 7) begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					if ($urandom_range(0, 1) && text.size() > 1)
						text.delete($urandom_range(0, text.size() - 1));
					else
						text.insert($urandom_range(0, text.size()),
							alphabet_char($urandom_range(0, 64)));
				end
			end
		end
		// Sometimes close the stream on a byte that is otherwise skipped.
		if ($urandom_range(0, 4) == 0)
			text.push_back(skip_char());
		foreach (text[i]) begin
			if ($urandom_range(0, 9) == 0)
				send_char(skip_char(), 1'b0);
			send_char(text[i], i == text.size() - 1);
		end
	endtask

	// Result side: check every accepted result, and stall ready in random bursts.
	// Once, after about a hundred requests, hold ready low for a long stretch so
	// the block backs up into its input.
	initial begin : result_sink
		int          stall_left;
		int          hold_left;
		bit          hold_done;
		logic        next_ready;
		b64_result_t got;
		stall_left   = 0;
		hold_left    = 0;
		hold_done    = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.kind        = out_ch.kind;
				got.data_byte   = out_ch.data_byte;
				got.status      = out_ch.status;
				got.byte_total  = out_ch.byte_total;
				got.last_of_run = out_ch.last_of_run;
				sb.check_result(got);
			end
			if (!hold_done && sb.accepted >= 100) begin
				hold_left = 300;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			out_ch.ready <= next_ready;
		end
	end

	initial begin : stimulus
		bit paused;
		paused           = 0;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.char_in    = '0;
		in_ch.final_char = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two quads, the second padded twice so the flush trims to one byte;
		// the all-zero and all-one bytes are skipped along the way.
		send_char(8'h00, 1'b0);
		send_text("TWFu");
		send_char(8'hFF, 1'b0);
		send_text("QQ=");
		send_char(CHAR_PAD, 1'b1);
		// Plus and slash, a single pad (two-byte trim), closed by a skipped byte.
		send_text("+/9zQUI=");
		send_char(8'h80, 1'b1);
		// A stream with no valid character at all.
		send_char(8'h20, 1'b1);
		// A partial quad left at the end.
		send_text("ab");
		send_char("c", 1'b1);

		while (sb.accepted < 280) begin
			if (sb.accepted >= 240)
				quiet = 1;
			// Once mid-run, drop valid and let the block drain completely.
			if (!paused && sb.accepted >= 150) begin
				in_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while (sb.pending() != 0);
				paused = 1;
			end
			send_random_stream();
		end
		in_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// Catch any stray result after the last one awaited.
		repeat (20) @(posedge clk);
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
